[design/ltr_pkg.sv]
// Package for the linear tween ramp: transaction payload types and reset constants.
// No dependencies; compile first.
package ltr_pkg;

    typedef struct packed {
        logic        operation;
        logic [31:0] now_ms;
        logic [15:0] duration_ms;
        logic [3:0]  target_eye_shape;
        logic [7:0]  target_pupil_radius;
        logic [7:0]  target_eyelid_open;
        logic [7:0]  target_blink_interval;
        logic [3:0]  target_aura;
        logic [3:0]  target_sound;
    } item_t;

    typedef struct packed {
        logic [3:0] eye_shape;
        logic [7:0] pupil_radius;
        logic [7:0] eyelid_open;
        logic [7:0] blink_interval;
        logic [3:0] aura;
        logic [3:0] sound;
        logic       animating;
    } result_t;

    localparam logic OP_SET_TARGET = 1'b0;
    localparam logic OP_TICK       = 1'b1;

    localparam logic [7:0] RESET_PUPIL  = 8'd5;
    localparam logic [7:0] RESET_EYELID = 8'd100;
    localparam logic [7:0] RESET_BLINK  = 8'd4;

endpackage

[design/ltr_item_if.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on ltr_pkg for the payload types.
interface ltr_item_if;
    logic          valid;
    logic          ready;
    ltr_pkg::item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ltr_result_if;
    logic             valid;
    logic             ready;
    ltr_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[design/linear_tween_ramp.sv]
// Linear tween ramp: set-target and tick transactions drive a ramp of two values.
// Depends on ltr_pkg and the channel interfaces in ltr_item_if.sv.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  item     | in        | operation, now_ms, duration_ms, target fields
//  result   | out       | current values and the animating flag
//
// A set-target transaction, or a tick with no ramp running, goes straight to
// S_DONE. A tick during a ramp does the elapsed-time compare in S_CHECK; unless
// the ramp has ended it then does, per ramped value, one multiply, eight steps
// of the shared restoring divider and one update in S_APPLY before S_DONE loads the result register.
// item.ready is high only while the sequencer is idle; a result waiting in the
// output register does not block the next transaction, but the one after it
// waits until that result is taken. Reset is asynchronous and restores the
// power-on expression values.
module linear_tween_ramp #(
    parameter int TIME_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    ltr_item_if.sink      item,
    ltr_result_if.source  result
);
    import ltr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [3:0]           cur_shape_reg, cur_shape_next;
    logic [7:0]           cur_pupil_reg, cur_pupil_next;
    logic [7:0]           cur_eyelid_reg, cur_eyelid_next;
    logic [7:0]           cur_blink_reg, cur_blink_next;
    logic [3:0]           cur_aura_reg, cur_aura_next;
    logic [3:0]           cur_sound_reg, cur_sound_next;
    logic [3:0]           goal_shape_reg, goal_shape_next;
    logic [7:0]           goal_pupil_reg, goal_pupil_next;
    logic [7:0]           goal_eyelid_reg, goal_eyelid_next;
    logic [3:0]           goal_aura_reg, goal_aura_next;
    logic [3:0]           goal_sound_reg, goal_sound_next;
    logic [7:0]           begin_pupil_reg, begin_pupil_next;
    logic [7:0]           begin_eyelid_reg, begin_eyelid_next;
    logic [TIME_BITS-1:0] begin_time_reg, begin_time_next;
    logic [15:0]          ramp_length_reg, ramp_length_next;
    logic                 busy_reg, busy_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic                 chan_reg, chan_next;
    logic                 down_reg, down_next;
    logic [15:0]          rem_reg, rem_next;
    logic [7:0]           quo_reg, quo_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_data_reg, out_data_next;

    logic        accept;
    logic        same_goal;
    logic [7:0]  sel_begin;
    logic [7:0]  sel_goal;
    logic        sel_down;
    logic [7:0]  mag;
    logic [23:0] product;
    logic [16:0] partial;
    logic        fits;
    logic [16:0] diff;
    logic [7:0]  ramped;
    logic        out_free;

    assign item.ready     = (state_reg == S_IDLE);
    assign accept         = item.valid && item.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;
    assign out_free       = !out_valid_reg || result.ready;

    assign same_goal = (goal_shape_reg == item.payload.target_eye_shape)
                    && (goal_pupil_reg == item.payload.target_pupil_radius)
                    && (goal_eyelid_reg == item.payload.target_eyelid_open)
                    && (goal_aura_reg == item.payload.target_aura)
                    && (goal_sound_reg == item.payload.target_sound);

    // Operand selection for the value being ramped in this pass.
    assign sel_begin = chan_reg ? begin_eyelid_reg : begin_pupil_reg;
    assign sel_goal  = chan_reg ? goal_eyelid_reg : goal_pupil_reg;
    assign sel_down  = (sel_goal < sel_begin);
    assign mag       = sel_down ? (sel_begin - sel_goal) : (sel_goal - sel_begin);
    assign product   = {16'd0, mag} * {8'd0, elapsed_reg[15:0]};

    // One restoring division step; the remainder always stays below the divisor.
    assign partial = {rem_reg, quo_reg[7]};
    assign fits    = (partial >= {1'b0, ramp_length_reg});
    assign diff    = partial - {1'b0, ramp_length_reg};

    assign ramped = down_reg ? (sel_begin - quo_reg) : (sel_begin + quo_reg);

    always_comb
    begin
        state_next        = state_reg;
        cur_shape_next    = cur_shape_reg;
        cur_pupil_next    = cur_pupil_reg;
        cur_eyelid_next   = cur_eyelid_reg;
        cur_blink_next    = cur_blink_reg;
        cur_aura_next     = cur_aura_reg;
        cur_sound_next    = cur_sound_reg;
        goal_shape_next   = goal_shape_reg;
        goal_pupil_next   = goal_pupil_reg;
        goal_eyelid_next  = goal_eyelid_reg;
        goal_aura_next    = goal_aura_reg;
        goal_sound_next   = goal_sound_reg;
        begin_pupil_next  = begin_pupil_reg;
        begin_eyelid_next = begin_eyelid_reg;
        begin_time_next   = begin_time_reg;
        ramp_length_next  = ramp_length_reg;
        busy_next         = busy_reg;
        elapsed_next      = elapsed_reg;
        chan_next         = chan_reg;
        down_next         = down_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        cnt_next          = cnt_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        out_data_next     = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.payload.operation == OP_SET_TARGET)
                    begin
                        state_next = S_DONE;
                        if (!(same_goal && busy_reg))
                        begin
                            goal_shape_next   = item.payload.target_eye_shape;
                            goal_pupil_next   = item.payload.target_pupil_radius;
                            goal_eyelid_next  = item.payload.target_eyelid_open;
                            goal_aura_next    = item.payload.target_aura;
                            goal_sound_next   = item.payload.target_sound;
                            begin_pupil_next  = cur_pupil_reg;
                            begin_eyelid_next = cur_eyelid_reg;
                            begin_time_next   = item.payload.now_ms[TIME_BITS-1:0];
                            ramp_length_next  = item.payload.duration_ms;
                            cur_shape_next    = item.payload.target_eye_shape;
                            cur_aura_next     = item.payload.target_aura;
                            cur_sound_next    = item.payload.target_sound;
                            cur_blink_next    = item.payload.target_blink_interval;
                            if (item.payload.duration_ms == 16'd0)
                            begin
                                cur_pupil_next  = item.payload.target_pupil_radius;
                                cur_eyelid_next = item.payload.target_eyelid_open;
                                busy_next       = 1'b0;
                            end
                            else
                            begin
                                busy_next = 1'b1;
                            end
                        end
                    end
                    else if (busy_reg)
                    begin
                        elapsed_next = item.payload.now_ms[TIME_BITS-1:0] - begin_time_reg;
                        state_next   = S_CHECK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_CHECK:
            begin
                if (elapsed_reg >= TIME_BITS'(ramp_length_reg))
                begin
                    cur_pupil_next  = goal_pupil_reg;
                    cur_eyelid_next = goal_eyelid_reg;
                    busy_next       = 1'b0;
                    state_next      = S_DONE;
                end
                else
                begin
                    chan_next  = 1'b0;
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                // The quotient is below 256, so the top 16 bits start as remainder.
                down_next  = sel_down;
                rem_next   = product[23:8];
                quo_next   = product[7:0];
                cnt_next   = 3'd0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                rem_next = fits ? diff[15:0] : partial[15:0];
                quo_next = {quo_reg[6:0], fits};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    state_next = S_APPLY;
                end
            end

            S_APPLY:
            begin
                if (chan_reg)
                begin
                    cur_eyelid_next = ramped;
                    state_next      = S_DONE;
                end
                else
                begin
                    cur_pupil_next = ramped;
                    chan_next      = 1'b1;
                    state_next     = S_MUL;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.eye_shape      = cur_shape_reg;
                    out_data_next.pupil_radius   = cur_pupil_reg;
                    out_data_next.eyelid_open    = cur_eyelid_reg;
                    out_data_next.blink_interval = cur_blink_reg;
                    out_data_next.aura           = cur_aura_reg;
                    out_data_next.sound          = cur_sound_reg;
                    out_data_next.animating      = busy_reg;
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cur_shape_reg    <= 4'd0;
            cur_pupil_reg    <= RESET_PUPIL;
            cur_eyelid_reg   <= RESET_EYELID;
            cur_blink_reg    <= RESET_BLINK;
            cur_aura_reg     <= 4'd0;
            cur_sound_reg    <= 4'd0;
            goal_shape_reg   <= 4'd0;
            goal_pupil_reg   <= RESET_PUPIL;
            goal_eyelid_reg  <= RESET_EYELID;
            goal_aura_reg    <= 4'd0;
            goal_sound_reg   <= 4'd0;
            begin_pupil_reg  <= RESET_PUPIL;
            begin_eyelid_reg <= RESET_EYELID;
            begin_time_reg   <= '0;
            ramp_length_reg  <= 16'd0;
            busy_reg         <= 1'b0;
            chan_reg         <= 1'b0;
            cnt_reg          <= 3'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cur_shape_reg    <= cur_shape_next;
            cur_pupil_reg    <= cur_pupil_next;
            cur_eyelid_reg   <= cur_eyelid_next;
            cur_blink_reg    <= cur_blink_next;
            cur_aura_reg     <= cur_aura_next;
            cur_sound_reg    <= cur_sound_next;
            goal_shape_reg   <= goal_shape_next;
            goal_pupil_reg   <= goal_pupil_next;
            goal_eyelid_reg  <= goal_eyelid_next;
            goal_aura_reg    <= goal_aura_next;
            goal_sound_reg   <= goal_sound_next;
            begin_pupil_reg  <= begin_pupil_next;
            begin_eyelid_reg <= begin_eyelid_next;
            begin_time_reg   <= begin_time_next;
            ramp_length_reg  <= ramp_length_next;
            busy_reg         <= busy_next;
            chan_reg         <= chan_next;
            cnt_reg          <= cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Datapath registers; their contents are only used once written.
    always_ff @(posedge clk)
    begin
        elapsed_reg  <= elapsed_next;
        down_reg     <= down_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        out_data_reg <= out_data_next;
    end

endmodule
